/* hw/rtl/gpu_pushbuffer_command_parser_assert.svh */
// Assertion macros shared by the pushbuffer command parser RTL.
`ifndef GPU_PUSHBUFFER_COMMAND_PARSER_ASSERT_SVH
`define GPU_PUSHBUFFER_COMMAND_PARSER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define GPC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gpc same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define GPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gpc next-cycle check failed");

`endif

/* hw/rtl/gpc_pkg.sv */
// Types and constants for the pushbuffer command parser.
package gpc_pkg;

    localparam logic [31:0] ALIGN_MASK    = 32'hFFFF_FFFC;
    localparam logic [31:0] OLD_JUMP_MASK = 32'hE000_0003;
    localparam logic [31:0] OLD_JUMP_CODE = 32'h2000_0000;
    localparam logic [31:0] OLD_JUMP_ADDR = 32'h1FFF_FFFF;
    localparam logic [31:0] RETURN_WORD   = 32'h0002_0000;
    localparam logic [31:0] METHOD_MASK   = 32'hE003_0003;
    localparam logic [31:0] METHOD_NONINC = 32'h4000_0000;
    localparam int          COUNT_SHIFT   = 18;
    localparam int          METHOD_SHIFT  = 2;
    localparam int          SUBCH_SHIFT   = 13;
    localparam int          METHOD_W      = 11;
    localparam int          SUBCH_W       = 3;

    // Low two bits of a header word select the jump and call forms
    localparam logic [1:0] HDR_NEW_JUMP = 2'd1;
    localparam logic [1:0] HDR_CALL     = 2'd2;

    // Configuration register indexes
    localparam logic CFG_PUSHER_ENABLED = 1'b0;
    localparam logic CFG_BUFFER_LIMIT   = 1'b1;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_LIMIT    = 3'd1,
        ERR_CALL     = 3'd2,
        ERR_RETURN   = 3'd3,
        ERR_RESERVED = 3'd4
    } err_t;

    typedef struct packed {
        logic                load_pointer;
        logic [31:0]         new_pointer;
        logic [31:0]         write_pointer;
        logic [31:0]         buffer_word;
        logic                clear_suspend;
    } item_t;

    typedef struct packed {
        logic [31:0]         get_offset;
        logic [31:0]         return_offset;
        logic                in_subroutine;
        logic [31:0]         jump_origin;
        logic [METHOD_W-1:0] cur_method;
        logic [SUBCH_W-1:0]  cur_subchannel;
        logic                cur_nonincreasing;
        logic [METHOD_W-1:0] count_left;
        logic [METHOD_W-1:0] count_done;
        logic                halted;
        logic                irq_pending;
        err_t                last_error;
    } state_t;

    typedef struct packed {
        logic [31:0]         read_pointer;
        logic                buffer_empty;
        logic                entry_valid;
        logic [METHOD_W-1:0] entry_method;
        logic [SUBCH_W-1:0]  entry_subchannel;
        logic                entry_nonincreasing;
        logic [31:0]         entry_data;
        logic [METHOD_W-1:0] params_left;
        logic [METHOD_W-1:0] params_done;
        err_t                error_code;
        logic                suspended;
        logic                interrupt;
    } result_t;

    typedef struct packed {
        logic                pusher_enabled;
        logic [31:0]         buffer_limit;
    } cfg_t;

endpackage

/* hw/rtl/gpc_decode.sv */
// Single-step decode of one pushbuffer beat: next state and result.
module gpc_decode
(
    input  gpc_pkg::item_t   item,
    input  gpc_pkg::state_t  state,
    input  gpc_pkg::cfg_t    cfg,
    output gpc_pkg::state_t  state_next,
    output gpc_pkg::result_t result
);

    logic [31:0] newp;
    logic [31:0] putp;
    logic [31:0] word;
    logic [31:0] kind;
    logic [31:0] next_offset;

    assign newp        = item.new_pointer & gpc_pkg::ALIGN_MASK;
    assign putp        = item.write_pointer & gpc_pkg::ALIGN_MASK;
    assign word        = item.buffer_word;
    assign kind        = word & gpc_pkg::METHOD_MASK;
    assign next_offset = state.get_offset + 32'd4;

    // Apply clear, then load or decode one word
    always_comb
    begin
        gpc_pkg::state_t s;
        logic            ev;
        s  = state;
        ev = 1'b0;

        if (item.clear_suspend)
        begin
            s.halted      = 1'b0;
            s.irq_pending = 1'b0;
            s.last_error  = gpc_pkg::ERR_NONE;
        end

        if (item.load_pointer)
        begin
            s.get_offset = newp;
        end
        else if (s.get_offset != putp && cfg.pusher_enabled && !s.halted)
        begin
            if (s.get_offset >= cfg.buffer_limit)
            begin
                s.last_error  = gpc_pkg::ERR_LIMIT;
                s.halted      = 1'b1;
                s.irq_pending = 1'b1;
            end
            else
            begin
                s.get_offset = next_offset;
                if (s.count_left != '0)
                begin
                    // Parameter word: emit an entry
                    ev = 1'b1;
                    if (!s.cur_nonincreasing)
                    begin
                        s.cur_method = s.cur_method + 11'd1;
                    end
                    s.count_left = s.count_left - 11'd1;
                    s.count_done = s.count_done + 11'd1;
                end
                else if ((word & gpc_pkg::OLD_JUMP_MASK) == gpc_pkg::OLD_JUMP_CODE)
                begin
                    s.jump_origin = next_offset;
                    s.get_offset  = word & gpc_pkg::OLD_JUMP_ADDR;
                end
                else if (word[1:0] == gpc_pkg::HDR_NEW_JUMP)
                begin
                    s.jump_origin = next_offset;
                    s.get_offset  = word & gpc_pkg::ALIGN_MASK;
                end
                else if (word[1:0] == gpc_pkg::HDR_CALL)
                begin
                    if (s.in_subroutine)
                    begin
                        s.last_error  = gpc_pkg::ERR_CALL;
                        s.halted      = 1'b1;
                        s.irq_pending = 1'b1;
                    end
                    else
                    begin
                        s.return_offset = next_offset;
                        s.in_subroutine = 1'b1;
                        s.get_offset    = word & gpc_pkg::ALIGN_MASK;
                    end
                end
                else if (word == gpc_pkg::RETURN_WORD)
                begin
                    if (!s.in_subroutine)
                    begin
                        s.last_error  = gpc_pkg::ERR_RETURN;
                        s.halted      = 1'b1;
                        s.irq_pending = 1'b1;
                    end
                    else
                    begin
                        s.get_offset    = s.return_offset & gpc_pkg::ALIGN_MASK;
                        s.in_subroutine = 1'b0;
                    end
                end
                else if (kind == '0 || kind == gpc_pkg::METHOD_NONINC)
                begin
                    // Method header: latch method, subchannel and count
                    s.cur_nonincreasing = (kind != '0);
                    s.cur_method        = word[gpc_pkg::METHOD_SHIFT +: gpc_pkg::METHOD_W];
                    s.cur_subchannel    = word[gpc_pkg::SUBCH_SHIFT +: gpc_pkg::SUBCH_W];
                    s.count_left        = word[gpc_pkg::COUNT_SHIFT +: gpc_pkg::METHOD_W];
                    s.count_done        = '0;
                end
                else
                begin
                    s.last_error  = gpc_pkg::ERR_RESERVED;
                    s.halted      = 1'b1;
                    s.irq_pending = 1'b1;
                end
            end
        end

        state_next = s;

        result.read_pointer        = s.get_offset;
        result.buffer_empty        = (s.get_offset == putp);
        result.entry_valid         = ev;
        result.entry_method        = ev ? state.cur_method : '0;
        result.entry_subchannel    = ev ? state.cur_subchannel : '0;
        result.entry_nonincreasing = ev ? state.cur_nonincreasing : 1'b0;
        result.entry_data          = ev ? word : '0;
        result.params_left         = s.count_left;
        result.params_done         = s.count_done;
        result.error_code          = s.last_error;
        result.suspended           = s.halted;
        result.interrupt           = s.irq_pending;
    end

endmodule

/* hw/rtl/gpu_pushbuffer_command_parser.sv */
// Pushbuffer command parser top level: input stage, decode, result stage and state.
// Takes one pushbuffer beat per clock while in_stall is low and returns one result beat per input beat.
// A beat is held in the input register and is decoded in a single pass into
// the result register, and sustained rate is one beat per cycle while out_stall is low;
// the fetcher state (read pointer, call return, method counters, error
// status) updates at the same edge the result is registered, so the next beat
// already sees it. The input side accepts while a finished result waits, as long
// as the input register is empty or its beat moves on at that edge.
`include "gpu_pushbuffer_command_parser_assert.svh"

module gpu_pushbuffer_command_parser
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        load_pointer,
    input  logic [31:0] new_pointer,
    input  logic [31:0] write_pointer,
    input  logic [31:0] buffer_word,
    input  logic        clear_suspend,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_pointer,
    output logic        buffer_empty,
    output logic        entry_valid,
    output logic [10:0] entry_method,
    output logic [2:0]  entry_subchannel,
    output logic        entry_nonincreasing,
    output logic [31:0] entry_data,
    output logic [10:0] params_left,
    output logic [10:0] params_done,
    output logic [2:0]  error_code,
    output logic        suspended,
    output logic        interrupt
);

    gpc_pkg::cfg_t    cfg_reg;
    gpc_pkg::item_t   item_reg;
    logic             item_vld_reg;
    gpc_pkg::state_t  state_reg;
    gpc_pkg::state_t  state_next;
    gpc_pkg::result_t result_reg;
    gpc_pkg::result_t result_next;
    logic             out_vld_reg;
    logic             advance;
    logic             in_take;

    // Move the held beat into the result stage when that stage frees up
    assign advance  = item_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = item_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                gpc_pkg::CFG_PUSHER_ENABLED: cfg_reg.pusher_enabled <= cfg_data[0];
                gpc_pkg::CFG_BUFFER_LIMIT:   cfg_reg.buffer_limit   <= cfg_data;
                default:                     cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else if (in_take)
        begin
            item_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_vld_reg <= 1'b0;
        end
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= '{load_pointer, new_pointer, write_pointer, buffer_word,
                          clear_suspend};
        end
    end

    gpc_decode u_decode
    (
        .item       (item_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Fetcher state and result valid advance together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            state_reg   <= state_next;
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid           = out_vld_reg;
    assign read_pointer        = result_reg.read_pointer;
    assign buffer_empty        = result_reg.buffer_empty;
    assign entry_valid         = result_reg.entry_valid;
    assign entry_method        = result_reg.entry_method;
    assign entry_subchannel    = result_reg.entry_subchannel;
    assign entry_nonincreasing = result_reg.entry_nonincreasing;
    assign entry_data          = result_reg.entry_data;
    assign params_left         = result_reg.params_left;
    assign params_done         = result_reg.params_done;
    assign error_code          = result_reg.error_code;
    assign suspended           = result_reg.suspended;
    assign interrupt           = result_reg.interrupt;

    `GPC_ASSERT_NOW(a_stall_only_when_full, in_stall, out_vld_reg && out_stall && item_vld_reg)
    `GPC_ASSERT_NEXT(a_advance_fills_out, advance, out_vld_reg)
    `GPC_ASSERT_NOW(a_halt_irq_paired, 1'b1, (state_reg.halted == state_reg.irq_pending) && (state_reg.halted == (state_reg.last_error != gpc_pkg::ERR_NONE)))
    `GPC_ASSERT_NOW(a_entry_not_halted, out_vld_reg && result_reg.entry_valid, !result_reg.suspended && result_reg.error_code == gpc_pkg::ERR_NONE)

endmodule

/* verif/gpu_pushbuffer_command_parser_checker.sv */
// Scoreboard for the pushbuffer command parser: tracks fetcher state and checks result beats.
`timescale 1ns / 100ps

module gpu_pushbuffer_command_parser_checker
    import gpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        load_pointer,
    input  logic [31:0] new_pointer,
    input  logic [31:0] write_pointer,
    input  logic [31:0] buffer_word,
    input  logic        clear_suspend,

    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] read_pointer,
    input  logic        buffer_empty,
    input  logic        entry_valid,
    input  logic [10:0] entry_method,
    input  logic [2:0]  entry_subchannel,
    input  logic        entry_nonincreasing,
    input  logic [31:0] entry_data,
    input  logic [10:0] params_left,
    input  logic [10:0] params_done,
    input  logic [2:0]  error_code,
    input  logic        suspended,
    input  logic        interrupt,

    output int          outstanding,
    output int          fail_count
);

    state_t  fetch;
    cfg_t    settings;
    result_t pending_results[$];
    int      open_beats;
    int      miss_total;

    // Suspend the pusher and latch the error for the interrupt
    task automatic record_fault(input err_t code);
        fetch.last_error  = code;
        fetch.halted      = 1'b1;
        fetch.irq_pending = 1'b1;
    endtask

    // Advance the fetcher by one accepted beat and build the result it must return
    task automatic step_fetcher(input item_t beat, output result_t res);
        logic [31:0] put_ptr;
        logic [31:0] word;
        logic [31:0] kind;
        put_ptr = beat.write_pointer & ALIGN_MASK;
        word    = beat.buffer_word;
        kind    = word & METHOD_MASK;
        res     = '0;

        // Clear comes ahead of anything else in the beat
        if (beat.clear_suspend)
        begin
            fetch.halted      = 1'b0;
            fetch.irq_pending = 1'b0;
            fetch.last_error  = ERR_NONE;
        end

        if (beat.load_pointer)
        begin
            fetch.get_offset = beat.new_pointer & ALIGN_MASK;
        end
        else if (fetch.get_offset != put_ptr && settings.pusher_enabled && !fetch.halted)
        begin
            if (fetch.get_offset >= settings.buffer_limit)
            begin
                // Pointer holds on a limit fault
                record_fault(ERR_LIMIT);
            end
            else
            begin
                fetch.get_offset = fetch.get_offset + 32'd4;
                if (fetch.count_left != '0)
                begin
                    // Parameter word: emit an entry, step the method for increasing headers
                    res.entry_valid         = 1'b1;
                    res.entry_method        = fetch.cur_method;
                    res.entry_subchannel    = fetch.cur_subchannel;
                    res.entry_nonincreasing = fetch.cur_nonincreasing;
                    res.entry_data          = word;
                    if (!fetch.cur_nonincreasing)
                        fetch.cur_method = fetch.cur_method + 11'd1;
                    fetch.count_left = fetch.count_left - 11'd1;
                    fetch.count_done = fetch.count_done + 11'd1;
                end
                else if ((word & OLD_JUMP_MASK) == OLD_JUMP_CODE)
                begin
                    fetch.jump_origin = fetch.get_offset;
                    fetch.get_offset  = word & OLD_JUMP_ADDR;
                end
                else if (word[1:0] == HDR_NEW_JUMP)
                begin
                    fetch.jump_origin = fetch.get_offset;
                    fetch.get_offset  = word & ALIGN_MASK;
                end
                else if (word[1:0] == HDR_CALL)
                begin
                    // Only one level of call is allowed
                    if (fetch.in_subroutine)
                    begin
                        record_fault(ERR_CALL);
                    end
                    else
                    begin
                        fetch.return_offset = fetch.get_offset;
                        fetch.in_subroutine = 1'b1;
                        fetch.get_offset    = word & ALIGN_MASK;
                    end
                end
                else if (word == RETURN_WORD)
                begin
                    if (!fetch.in_subroutine)
                    begin
                        record_fault(ERR_RETURN);
                    end
                    else
                    begin
                        fetch.get_offset    = fetch.return_offset & ALIGN_MASK;
                        fetch.in_subroutine = 1'b0;
                    end
                end
                else if (kind == 32'h0 || kind == METHOD_NONINC)
                begin
                    fetch.cur_nonincreasing = (kind == METHOD_NONINC);
                    fetch.cur_method        = word[METHOD_SHIFT +: METHOD_W];
                    fetch.cur_subchannel    = word[SUBCH_SHIFT +: SUBCH_W];
                    fetch.count_left        = word[COUNT_SHIFT +: METHOD_W];
                    fetch.count_done        = '0;
                end
                else
                begin
                    record_fault(ERR_RESERVED);
                end
            end
        end

        res.read_pointer = fetch.get_offset;
        res.buffer_empty = (fetch.get_offset == put_ptr);
        res.params_left  = fetch.count_left;
        res.params_done  = fetch.count_done;
        res.error_code   = fetch.last_error;
        res.suspended    = fetch.halted;
        res.interrupt    = fetch.irq_pending;
    endtask

    function automatic int field_diff(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    function automatic int result_diff(input result_t want, input result_t got);
        int bad;
        bad = 0;
        bad += field_diff("read_pointer", want.read_pointer, got.read_pointer);
        bad += field_diff("buffer_empty", 32'(want.buffer_empty), 32'(got.buffer_empty));
        bad += field_diff("entry_valid", 32'(want.entry_valid), 32'(got.entry_valid));
        bad += field_diff("entry_method", 32'(want.entry_method), 32'(got.entry_method));
        bad += field_diff("entry_subchannel", 32'(want.entry_subchannel),
                          32'(got.entry_subchannel));
        bad += field_diff("entry_nonincreasing", 32'(want.entry_nonincreasing),
                          32'(got.entry_nonincreasing));
        bad += field_diff("entry_data", want.entry_data, got.entry_data);
        bad += field_diff("params_left", 32'(want.params_left), 32'(got.params_left));
        bad += field_diff("params_done", 32'(want.params_done), 32'(got.params_done));
        bad += field_diff("error_code", 32'(want.error_code), 32'(got.error_code));
        bad += field_diff("suspended", 32'(want.suspended), 32'(got.suspended));
        bad += field_diff("interrupt", 32'(want.interrupt), 32'(got.interrupt));
        return bad;
    endfunction

    // Watch the register port and both channels on every edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        result_t got;
        item_t   beat;
        if (!rst_n)
        begin
            fetch      = '0;
            settings   = '0;
            open_beats = 0;
            miss_total = 0;
            pending_results.delete();
            outstanding <= 0;
            fail_count  <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_PUSHER_ENABLED: settings.pusher_enabled = cfg_data[0];
                    CFG_BUFFER_LIMIT:   settings.buffer_limit   = cfg_data;
                    default:            ;
                endcase
            end

            // Check the result beat against the oldest expectation
            if (out_valid && !out_stall)
            begin
                got.read_pointer        = read_pointer;
                got.buffer_empty        = buffer_empty;
                got.entry_valid         = entry_valid;
                got.entry_method        = entry_method;
                got.entry_subchannel    = entry_subchannel;
                got.entry_nonincreasing = entry_nonincreasing;
                got.entry_data          = entry_data;
                got.params_left         = params_left;
                got.params_done         = params_done;
                got.error_code          = err_t'(error_code);
                got.suspended           = suspended;
                got.interrupt           = interrupt;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result beat with none expected: read_pointer %h",
                             $time, read_pointer);
                    miss_total++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    open_beats--;
                    if (result_diff(want, got) != 0)
                        miss_total++;
                end
            end

            // Predict the result of each accepted input beat
            if (in_valid && !in_stall)
            begin
                beat.load_pointer  = load_pointer;
                beat.new_pointer   = new_pointer;
                beat.write_pointer = write_pointer;
                beat.buffer_word   = buffer_word;
                beat.clear_suspend = clear_suspend;
                step_fetcher(beat, want);
                pending_results.push_back(want);
                open_beats++;
            end

            outstanding <= open_beats;
            fail_count  <= miss_total;
        end
    end

endmodule

/* verif/gpu_pushbuffer_command_parser_tb.sv */
// Testbench top for the pushbuffer command parser: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module gpu_pushbuffer_command_parser_tb;
    import gpc_pkg::*;

    localparam int          HOLD_PHASE  = 4;
    localparam int          HOLD_CYCLES = 64;
    localparam logic [31:0] FAR_PUT     = 32'hFFFF_0000;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        load_pointer;
    logic [31:0] new_pointer;
    logic [31:0] write_pointer;
    logic [31:0] buffer_word;
    logic        clear_suspend;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] read_pointer;
    logic        buffer_empty;
    logic        entry_valid;
    logic [10:0] entry_method;
    logic [2:0]  entry_subchannel;
    logic        entry_nonincreasing;
    logic [31:0] entry_data;
    logic [10:0] params_left;
    logic [10:0] params_done;
    logic [2:0]  error_code;
    logic        suspended;
    logic        interrupt;
    int          outstanding;
    int          fail_count;

    int          send_idle_pct  = 20;
    int          recv_stall_pct = 81;
    int          phase_idx      = -1;
    int          beats_sent     = 0;
    logic [31:0] target_span    = 32'h0000_1000;
    logic        owe_clear      = 1'b0;

    gpu_pushbuffer_command_parser dut (.*);

    gpu_pushbuffer_command_parser_checker result_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the flow locks up
    initial
    begin
        #10_000_000;
        $display("gpu_pushbuffer_command_parser_tb failed");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off to back the block up
    initial
    begin : receiver
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (phase_idx == HOLD_PHASE && beats_sent >= 20 && !hold_done)
            begin
                out_stall <= 1'b1;
                hold_left = HOLD_CYCLES;
                hold_done = 1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    task automatic set_flow(input int mode);
        case (mode)
            0:       begin send_idle_pct = 20; recv_stall_pct = 81; end
            1:       begin send_idle_pct = 81; recv_stall_pct = 20; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // Offer one beat, idling first at random, and hold it until taken
    task automatic send_beat(input logic load, input logic [31:0] newp,
                             input logic [31:0] putp, input logic [31:0] word,
                             input logic clr);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        load_pointer  <= load;
        new_pointer   <= newp;
        write_pointer <= putp;
        buffer_word   <= word;
        clear_suspend <= clr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_sent++;
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        drain_results();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [31:0] make_header(input logic noninc, input logic [10:0] method,
                                                input logic [2:0] subch,
                                                input logic [10:0] count);
        logic [31:0] word;
        word = noninc ? METHOD_NONINC : 32'h0;
        word[COUNT_SHIFT +: METHOD_W]  = count;
        word[SUBCH_SHIFT +: SUBCH_W]   = subch;
        word[METHOD_SHIFT +: METHOD_W] = method;
        return word;
    endfunction

    function automatic logic [31:0] pick_target();
        return $urandom_range(0, target_span) & ALIGN_MASK;
    endfunction

    // Stream word: carry a clear after a deliberate error, or now and then anyway
    task automatic feed_word(input logic [31:0] word);
        logic clr;
        clr = owe_clear || ($urandom_range(0, 19) == 0);
        owe_clear = 1'b0;
        send_beat(1'b0, $urandom(), $urandom(), word, clr);
    endtask

    task automatic emit_method();
        int params;
        params = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
        feed_word(make_header(1'($urandom_range(0, 1)), 11'($urandom_range(0, 2047)),
                              3'($urandom_range(0, 7)), 11'(params)));
        repeat (params)
            feed_word($urandom());
    endtask

    // One well-formed command sequence with random content, or some noise
    task automatic emit_chunk();
        int          pick;
        logic [31:0] target;
        logic [31:0] word;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            emit_method();
        end
        else if (pick < 55)
        begin
            // Empty header: the next word is a header again
            feed_word(make_header(1'($urandom_range(0, 1)), 11'($urandom_range(0, 2047)),
                                  3'($urandom_range(0, 7)), 11'd0));
        end
        else if (pick < 65)
        begin
            target = pick_target();
            if ($urandom_range(0, 1))
                feed_word(OLD_JUMP_CODE | (target & OLD_JUMP_ADDR));
            else
                feed_word(target | HDR_NEW_JUMP);
        end
        else if (pick < 75)
        begin
            // Subroutine body, sometimes with a forbidden nested call
            feed_word(pick_target() | HDR_CALL);
            if ($urandom_range(0, 5) == 0)
            begin
                feed_word(pick_target() | HDR_CALL);
                owe_clear = 1'b1;
            end
            emit_method();
            feed_word(RETURN_WORD);
        end
        else if (pick < 80)
        begin
            feed_word(RETURN_WORD);
            owe_clear = 1'b1;
        end
        else if (pick < 85)
        begin
            word = $urandom();
            if ($urandom_range(0, 1))
                feed_word(word | 32'h3);
            else
                feed_word((word & ALIGN_MASK) | 32'h8000_0000);
            owe_clear = 1'b1;
        end
        else if (pick < 90)
        begin
            // Pointer load, sometimes right onto the put pointer so words are skipped
            target = $urandom_range(0, target_span);
            if ($urandom_range(0, 2) == 0)
            begin
                send_beat(1'b1, target, target ^ $urandom_range(0, 3), $urandom(), owe_clear);
                repeat ($urandom_range(1, 3))
                    send_beat(1'b0, $urandom(), target, $urandom(), 1'b0);
            end
            else
            begin
                send_beat(1'b1, target, $urandom(), $urandom(),
                          owe_clear || $urandom_range(0, 1));
            end
            owe_clear = 1'b0;
        end
        else if (pick < 95)
        begin
            send_beat(1'($urandom_range(0, 1)), $urandom(), $urandom(), $urandom(),
                      1'($urandom_range(0, 1)));
        end
        else
        begin
            owe_clear = 1'b1;
            emit_method();
        end
    endtask

    initial
    begin
        logic        en;
        logic [31:0] lim;
        int          quota;
        int          mode;

        rst_n         <= 1'b0;
        cfg_write     <= 1'b0;
        cfg_index     <= CFG_PUSHER_ENABLED;
        cfg_data      <= 32'h0;
        in_valid      <= 1'b0;
        load_pointer  <= 1'b0;
        new_pointer   <= 32'h0;
        write_pointer <= 32'h0;
        buffer_word   <= 32'h0;
        clear_suspend <= 1'b0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed: pusher still disabled after reset
        set_flow(0);
        send_beat(1'b1, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0);
        send_beat(1'b0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0);

        // Zero limit: first decode faults, then the pusher stays suspended
        write_reg(CFG_PUSHER_ENABLED, 32'h1);
        send_beat(1'b0, 32'h0, 32'h10, 32'h0, 1'b0);
        send_beat(1'b0, 32'h0, 32'h10, make_header(1'b0, 11'd1, 3'd0, 11'd1), 1'b0);
        // Clear and load in the same beat
        send_beat(1'b1, 32'h0000_0103, 32'h0, 32'h0, 1'b1);

        write_reg(CFG_BUFFER_LIMIT, 32'hFFFF_FFFF);
        // Increasing method wrapping past the top index
        send_beat(1'b0, $urandom(), FAR_PUT, make_header(1'b0, 11'h7FF, 3'd7, 11'd3), 1'b0);
        send_beat(1'b0, $urandom(), FAR_PUT, 32'hFFFF_FFFF, 1'b0);
        send_beat(1'b0, $urandom(), FAR_PUT, 32'h0000_0000, 1'b0);
        send_beat(1'b0, $urandom(), FAR_PUT, 32'hA5A5_A5A5, 1'b0);
        // Non-increasing method
        send_beat(1'b0, $urandom(), FAR_PUT, make_header(1'b1, 11'd5, 3'd1, 11'd2), 1'b0);
        send_beat(1'b0, $urandom(), FAR_PUT, 32'h5A5A_5A5A, 1'b0);
        send_beat(1'b0, $urandom(), FAR_PUT, 32'h1234_5678, 1'b0);
        // Empty header, old jump to the top of its range, new jump
        send_beat(1'b0, $urandom(), FAR_PUT, 32'h0, 1'b0);
        send_beat(1'b0, $urandom(), FAR_PUT, OLD_JUMP_CODE | 32'h1FFF_FFFC, 1'b0);
        send_beat(1'b0, $urandom(), FAR_PUT, 32'h0000_0200 | HDR_NEW_JUMP, 1'b0);
        // Call, nested call, return, stray return
        send_beat(1'b0, $urandom(), FAR_PUT, 32'h0000_0400 | HDR_CALL, 1'b0);
        send_beat(1'b0, $urandom(), FAR_PUT, 32'h0000_0800 | HDR_CALL, 1'b0);
        send_beat(1'b0, $urandom(), FAR_PUT, RETURN_WORD, 1'b1);
        send_beat(1'b0, $urandom(), FAR_PUT, RETURN_WORD, 1'b0);
        // Reserved headers: odd low bits, then high kind bits
        send_beat(1'b0, $urandom(), FAR_PUT, 32'h0000_0003, 1'b1);
        send_beat(1'b0, $urandom(), FAR_PUT, 32'h8000_0000, 1'b1);
        // Pointer wraps past the top of the address space
        send_beat(1'b1, 32'hFFFF_FFFC, 32'h10, 32'h0, 1'b1);
        send_beat(1'b0, $urandom(), 32'h10, 32'h0, 1'b0);
        // Load onto the put pointer, then nothing is decoded
        send_beat(1'b1, 32'h40, 32'h43, $urandom(), 1'b0);
        send_beat(1'b0, $urandom(), 32'h40, $urandom(), 1'b0);

        // Random phases over several settings and flow modes
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       begin en = 1'b1; lim = 32'hFFFF_FFFF; quota = 400;
                               target_span = 32'hFFFF_FFFF; mode = 0; end
                1:       begin en = 1'b1; lim = 32'h0000_8000; quota = 350;
                               target_span = 32'h0000_9000; mode = 0; end
                2:       begin en = 1'b0; lim = 32'h0000_0000; quota = 30;
                               target_span = 32'h0000_1000; mode = 1; end
                3:       begin en = 1'b1; lim = $urandom(); quota = 400;
                               target_span = 32'h0001_0000; mode = 1; end
                4:       begin en = 1'b1; lim = 32'h4000_0000; quota = 400;
                               target_span = 32'h3FFF_FFFF; mode = 2; end
                default: begin en = 1'b1; lim = 32'hFFFF_FFFF; quota = 450;
                               target_span = 32'h0001_0000; mode = 2; end
            endcase
            write_reg(CFG_PUSHER_ENABLED, {31'h0, en});
            write_reg(CFG_BUFFER_LIMIT, lim);
            set_flow(mode);
            owe_clear  = 1'b0;
            beats_sent = 0;
            phase_idx  = ph;
            while (beats_sent < quota)
                emit_chunk();
        end

        drain_results();
        repeat (4)
            @(posedge clk);
        if (fail_count == 0)
            $display("gpu_pushbuffer_command_parser_tb passed");
        else
            $display("gpu_pushbuffer_command_parser_tb failed");
        $finish;
    end

endmodule
